// ===== src/mba_pkg.sv =====
package mba_pkg;

  localparam int MAX_BLOCK  = 64;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int SUM_W  = 14;
  localparam int DIV_W  = 7;
  localparam int ADDR_W = 12;
  localparam int LANES  = 3;

  localparam logic [7:0] REG_BLOCK_SIZE   = 8'd0;
  localparam logic [7:0] REG_IMAGE_WIDTH  = 8'd1;
  localparam logic [7:0] REG_IMAGE_HEIGHT = 8'd2;
  localparam logic [7:0] REG_GREY_MODE    = 8'd3;

  typedef logic [SUM_W-1:0] lane_t;
  typedef lane_t [LANES-1:0] sums_t;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   divisor;
  } div_req_t;

endpackage

// ===== src/mba_div.sv =====
module mba_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mba_pkg::div_req_t req,
  input  mba_pkg::sums_t    dividend,
  output mba_pkg::sums_t    quotient,
  output logic              done
);
  import mba_pkg::*;

  localparam logic [3:0] LAST_STEP = 4'(SUM_W - 1);

  logic                         busy_r;
  logic [3:0]                   step_r;
  logic                         done_r;
  logic [DIV_W-1:0]             dsr_r;
  logic [LANES-1:0][DIV_W-1:0]  rem_r;
  sums_t                        q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        dsr_r  <= req.divisor;
        q_r    <= dividend;
        rem_r  <= '0;
      end else if (busy_r) begin
        for (int i = 0; i < LANES; i++) begin
          if ({rem_r[i], q_r[i][SUM_W-1]} >= {1'b0, dsr_r}) begin
            rem_r[i] <= DIV_W'({rem_r[i], q_r[i][SUM_W-1]} - {1'b0, dsr_r});
            q_r[i]   <= {q_r[i][SUM_W-2:0], 1'b1};
          end else begin
            rem_r[i] <= DIV_W'({rem_r[i], q_r[i][SUM_W-1]});
            q_r[i]   <= {q_r[i][SUM_W-2:0], 1'b0};
          end
        end
        step_r <= step_r + 4'd1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

// ===== src/mba_band_ram.sv =====
module mba_band_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [mba_pkg::ADDR_W-1:0]    waddr,
  input  mba_pkg::sums_t                wdata,
  input  logic                          re,
  input  logic [mba_pkg::ADDR_W-1:0]    raddr,
  output mba_pkg::sums_t                rdata
);
  import mba_pkg::*;

  sums_t mem [MAX_WIDTH];
  sums_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/mosaic_block_averager.sv =====
// Mosaic block averager.
// Input channel: one RGB pixel per transfer (in_valid / in_stall), raster
// order. Result channel: one transfer per finished block (out_valid /
// out_stall) with block indices, average colour and a last-block flag.
// Configuration channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
// a write to one of the four registers restarts the frame at its first
// pixel. Writes are taken only between pixels, when no block is in flight,
// and a pending write holds off a waiting pixel.
// A pixel inside a block row segment is taken while the block stays ready
// for the next one. A pixel that ends a segment stalls the input through a
// 14-step divide of the segment sums, then a read-modify-write of the band
// memory; if it also ends a block, the band sums are then divided by the row
// count and the output register is loaded. The divider is the pacing unit.
// Reset sets block size 8, 640 x 480, colour mode, and clears the frame
// position. The band memory needs no clearing: each entry is written at a
// block's first row, where the value read from it is ignored.
// While out_stall is high the result holds and pixels keep flowing until a
// second result is ready; the block then stalls its input.
module mosaic_block_averager (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pix_red,
  input  logic [7:0]  in_pix_green,
  input  logic [7:0]  in_pix_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_block_col,
  output logic [11:0] out_block_row,
  output logic [7:0]  out_avg_red,
  output logic [7:0]  out_avg_green,
  output logic [7:0]  out_avg_blue,
  output logic        out_frame_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import mba_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV1, S_WB, S_DIV2, S_EMIT} state_t;

  state_t       state_r;
  logic [6:0]   block_size_r;
  logic [12:0]  image_width_r, image_height_r;
  logic         grey_mode_r;

  logic [11:0]  col_count_r, row_count_r, cur_block_col_r, cur_block_row_r;
  logic [5:0]   col_in_block_r, row_in_block_r;
  sums_t        seg_sum_r;

  logic [6:0]   segw_r, rows_r;
  logic         first_row_r, blk_end_r, frame_last_r;
  logic [11:0]  job_col_r, job_row_r;

  logic         out_valid_r, out_frame_done_r;
  logic [11:0]  out_col_r, out_row_r;
  logic [7:0]   out_red_r, out_green_r, out_blue_r;

  logic [6:0]   bs;
  logic [12:0]  w, h;
  logic         accept, last_col, last_row, seg_end, blk_end, cfg_fire;
  logic [9:0]   rgb_sum;
  logic [26:0]  grey_prod;
  logic [7:0]   grey;
  logic [7:0]   pr, pg, pb;
  sums_t        seg_new, band_new, div_q, band_rd, div_in;
  div_req_t     div_req;
  logic         div_done, ram_we;

  always_comb begin
    bs = (block_size_r == '0) ? 7'd1 :
         (block_size_r > 7'(MAX_BLOCK)) ? 7'(MAX_BLOCK) : block_size_r;
    w  = (image_width_r == '0) ? 13'd1 :
         (image_width_r > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : image_width_r;
    h  = (image_height_r == '0) ? 13'd1 :
         (image_height_r > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : image_height_r;
  end

  assign cfg_ready = (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign accept    = in_valid && !in_stall;

  assign last_col = ({1'b0, col_count_r} + 13'd1) >= w;
  assign last_row = ({1'b0, row_count_r} + 13'd1) >= h;
  assign seg_end  = last_col || (({1'b0, col_in_block_r} + 7'd1) >= bs);
  assign blk_end  = last_row || (({1'b0, row_in_block_r} + 7'd1) >= bs);

  assign rgb_sum   = {2'b0, in_pix_red} + {2'b0, in_pix_green} + {2'b0, in_pix_blue};
  assign grey_prod = {17'b0, rgb_sum} * 27'd43691;
  assign grey      = grey_prod[24:17];

  always_comb begin
    pr = grey_mode_r ? grey : in_pix_red;
    pg = grey_mode_r ? grey : in_pix_green;
    pb = grey_mode_r ? grey : in_pix_blue;
    seg_new[0] = seg_sum_r[0] + lane_t'(pr);
    seg_new[1] = seg_sum_r[1] + lane_t'(pg);
    seg_new[2] = seg_sum_r[2] + lane_t'(pb);
    for (int i = 0; i < LANES; i++) begin
      band_new[i] = first_row_r ? div_q[i] : band_rd[i] + div_q[i];
    end
  end

  always_comb begin
    div_req.start   = 1'b0;
    div_req.divisor = segw_r;
    div_in          = seg_new;
    ram_we          = 1'b0;
    if (state_r == S_IDLE && accept && !cfg_fire && seg_end) begin
      div_req.start   = 1'b1;
      div_req.divisor = 7'({1'b0, col_in_block_r} + 7'd1);
    end else if (state_r == S_WB) begin
      ram_we = 1'b1;
      if (blk_end_r) begin
        div_req.start   = 1'b1;
        div_req.divisor = rows_r;
        div_in          = band_new;
      end
    end
  end

  mba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_in),
    .quotient (div_q),
    .done     (div_done)
  );

  mba_band_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (job_col_r),
    .wdata (band_new),
    .re    (accept && seg_end),
    .raddr (cur_block_col_r),
    .rdata (band_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      block_size_r    <= 7'd8;
      image_width_r   <= 13'd640;
      image_height_r  <= 13'd480;
      grey_mode_r     <= 1'b0;
      col_count_r     <= '0;
      row_count_r     <= '0;
      col_in_block_r  <= '0;
      row_in_block_r  <= '0;
      cur_block_col_r <= '0;
      cur_block_row_r <= '0;
      seg_sum_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cfg_fire) begin
            case (cfg_index)
              REG_BLOCK_SIZE:   block_size_r   <= cfg_data[6:0];
              REG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
              REG_IMAGE_HEIGHT: image_height_r <= cfg_data;
              REG_GREY_MODE:    grey_mode_r    <= cfg_data[0];
              default: ;
            endcase
            if (cfg_index == REG_BLOCK_SIZE || cfg_index == REG_IMAGE_WIDTH ||
                cfg_index == REG_IMAGE_HEIGHT || cfg_index == REG_GREY_MODE) begin
              col_count_r     <= '0;
              row_count_r     <= '0;
              col_in_block_r  <= '0;
              row_in_block_r  <= '0;
              cur_block_col_r <= '0;
              cur_block_row_r <= '0;
              seg_sum_r       <= '0;
            end
          end else if (accept) begin
            seg_sum_r    <= seg_end ? '0 : seg_new;
            segw_r       <= 7'({1'b0, col_in_block_r} + 7'd1);
            rows_r       <= 7'({1'b0, row_in_block_r} + 7'd1);
            first_row_r  <= (row_in_block_r == '0);
            blk_end_r    <= blk_end;
            frame_last_r <= last_col && last_row;
            job_col_r    <= cur_block_col_r;
            job_row_r    <= cur_block_row_r;
            if (seg_end) begin
              state_r <= S_DIV1;
            end
            if (last_col) begin
              col_count_r     <= '0;
              col_in_block_r  <= '0;
              cur_block_col_r <= '0;
              if (last_row) begin
                row_count_r     <= '0;
                row_in_block_r  <= '0;
                cur_block_row_r <= '0;
              end else begin
                row_count_r <= row_count_r + 12'd1;
                if (blk_end) begin
                  row_in_block_r  <= '0;
                  cur_block_row_r <= cur_block_row_r + 12'd1;
                end else begin
                  row_in_block_r <= row_in_block_r + 6'd1;
                end
              end
            end else begin
              col_count_r <= col_count_r + 12'd1;
              if (seg_end) begin
                col_in_block_r  <= '0;
                cur_block_col_r <= cur_block_col_r + 12'd1;
              end else begin
                col_in_block_r <= col_in_block_r + 6'd1;
              end
            end
          end
        end
        S_DIV1: begin
          if (div_done) begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          state_r <= blk_end_r ? S_DIV2 : S_IDLE;
        end
        S_DIV2: begin
          if (div_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r      <= 1'b1;
            out_col_r        <= job_col_r;
            out_row_r        <= job_row_r;
            out_red_r        <= div_q[0][7:0];
            out_green_r      <= div_q[1][7:0];
            out_blue_r       <= div_q[2][7:0];
            out_frame_done_r <= frame_last_r;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_block_col  = out_col_r;
  assign out_block_row  = out_row_r;
  assign out_avg_red    = out_red_r;
  assign out_avg_green  = out_green_r;
  assign out_avg_blue   = out_blue_r;
  assign out_frame_done = out_frame_done_r;

endmodule

// ===== src/mba_checker.sv =====
module mba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_block_col,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && cfg_ready && (in_stall == cfg_valid))
    else $error("block not idle after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_block_col))
    else $error("stalled result changed");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> cfg_ready)
    else $error("configuration transfer left block busy");

endmodule

bind mosaic_block_averager mba_checker u_mba_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_block_col (out_block_col),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);
